>>> design/assert_macros.svh
// Assertion helpers; both expect ports named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define DDRB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define DDRB_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/ddrb_pkg.sv
`timescale 1ns / 1ps
package ddrb_pkg;

   localparam int REG_WORDS   = 64;
   localparam int PARAM_WORDS = 32768;
   localparam int REG_AW      = $clog2(REG_WORDS);
   localparam int PARAM_AW    = $clog2(PARAM_WORDS);
   localparam int SLOT_W      = 15;
   localparam int CMD_W       = 2;
   localparam int WIDX_W      = 10;
   localparam int DATA_W      = 32;
   localparam int IRQ_WORDS   = 5;

   // item commands
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   // register word offsets
   localparam logic [WIDX_W-1:0] W_CONF  = 10'd0;
   localparam logic [WIDX_W-1:0] W_BUF0  = 10'd1;
   localparam logic [WIDX_W-1:0] W_BUF1  = 10'd2;
   localparam logic [WIDX_W-1:0] W_DBSEL = 10'd3;
   localparam logic [WIDX_W-1:0] W_CUR   = 10'd4;
   localparam logic [WIDX_W-1:0] W_TASK  = 10'd7;
   localparam logic [WIDX_W-1:0] W_IADDR = 10'd8;
   localparam logic [WIDX_W-1:0] W_IDATA = 10'd9;
   localparam logic [WIDX_W-1:0] W_IEN   = 10'd10;
   localparam logic [WIDX_W-1:0] W_ISTAT = 10'd15;
   localparam logic [WIDX_W-1:0] W_CHEN  = 10'd42;

   // bit masks
   localparam logic [DATA_W-1:0] CONF_EN_MASK = 32'h0000_0010;
   localparam logic [DATA_W-1:0] CH_A_MASK    = 32'h0000_4000;
   localparam logic [DATA_W-1:0] CH_B_MASK    = 32'h0000_8000;
   localparam logic [DATA_W-1:0] EOF_A_MASK   = 32'h0000_0002;
   localparam logic [DATA_W-1:0] EOF_B_MASK   = 32'h0000_0004;
   localparam logic [DATA_W-1:0] VSYNC_MASK   = 32'h0001_0000;

   // controller to datapath
   typedef struct packed {
      logic                load;
      logic                exec;
      logic                clear_we;
      logic [PARAM_AW-1:0] clear_addr;
   } ddrb_cmd_type;

endpackage

>>> design/ddrb_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ddrb_ctrl
   import ddrb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ddrb_cmd_type cmd_o
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   localparam logic [PARAM_AW-1:0] CLR_LAST = PARAM_AW'(PARAM_WORDS - 1);

   logic [1:0]          state_ff, state_in;
   logic [PARAM_AW-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      cmd_o      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd_o.clear_we   = 1'b1;
            cmd_o.clear_addr = clr_cnt_ff;
            clr_cnt_in       = clr_cnt_ff + PARAM_AW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_o.load = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd_o.exec = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   `DDRB_ASSERT_RST(a_reset_clears, reset |=> (state_ff == ST_CLEAR && clr_cnt_ff == '0), "reset must restart the clearing pass")
   `DDRB_ASSERT(a_load_to_exec, (state_ff == ST_IDLE && start) |=> (state_ff == ST_EXEC), "accepted item must execute next cycle")
   `DDRB_ASSERT(a_clear_holds, (state_ff == ST_CLEAR && clr_cnt_ff != CLR_LAST) |=> (state_ff == ST_CLEAR), "clearing pass left early")

endmodule

>>> design/ddrb_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ddrb_datapath
   import ddrb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ddrb_cmd_type      cmd_i,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [WIDX_W-1:0] req_word_index,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_irq_level
);

   function automatic logic [31:0] ima_step(input logic [31:0] a);
      logic [31:0] n;
      n = a + 32'd1;
      if (n[2:0] == 3'd5) begin
         n = {n[31:3] + 29'd1, 3'd0};
      end
      return n;
   endfunction

   function automatic logic [SLOT_W-1:0] ima_slot(input logic [31:0] a);
      return {a[19:16], a[10:3], a[2:0]};
   endfunction

   // memories
   logic [DATA_W-1:0] reg_mem   [REG_WORDS];
   logic [DATA_W-1:0] param_mem [PARAM_WORDS];
   logic [REG_WORDS-1:0] reg_vld_ff;

   // latched item
   logic [CMD_W-1:0]  cmd_ff;
   logic [WIDX_W-1:0] widx_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic              in_range_ff;
   logic [DATA_W-1:0] reg_rdata_ff;
   logic              reg_vld_rd_ff;
   logic [DATA_W-1:0] param_rdata_ff;

   // dedicated registers
   logic [DATA_W-1:0] conf_ff,  conf_in;
   logic [DATA_W-1:0] buf0_ff,  buf0_in;
   logic [DATA_W-1:0] buf1_ff,  buf1_in;
   logic [DATA_W-1:0] dbsel_ff, dbsel_in;
   logic [DATA_W-1:0] cur_ff,   cur_in;
   logic [DATA_W-1:0] iaddr_ff, iaddr_in;
   logic [DATA_W-1:0] chen_ff,  chen_in;
   logic [DATA_W-1:0] ien_ff   [IRQ_WORDS];
   logic [DATA_W-1:0] ien_in   [IRQ_WORDS];
   logic [DATA_W-1:0] istat_ff [IRQ_WORDS];
   logic [DATA_W-1:0] istat_in [IRQ_WORDS];
   logic              irq_ff, irq_in;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_rdata_ff, rsp_rdata_in;

   logic              req_in_range;
   logic [DATA_W-1:0] reg_word;
   logic              gen_we;
   logic [DATA_W-1:0] gen_wdata;
   logic              prm_we;
   logic              irq_upd;
   logic              irq_any;
   logic              irq_now;
   logic              is_ien, is_istat;
   logic [2:0]        ien_idx, istat_idx;
   logic              prm_wen;
   logic [PARAM_AW-1:0] prm_waddr;
   logic [DATA_W-1:0]   prm_wdata;
   logic [PARAM_AW-1:0] prm_slot;

   assign req_in_range = (req_word_index < WIDX_W'(REG_WORDS));
   assign reg_word     = reg_vld_rd_ff ? reg_rdata_ff : '0;
   assign is_ien       = (widx_ff >= W_IEN) && (widx_ff < W_ISTAT);
   assign is_istat     = (widx_ff >= W_ISTAT) && (widx_ff < W_ISTAT + WIDX_W'(IRQ_WORDS));
   assign ien_idx      = 3'(widx_ff - W_IEN);
   assign istat_idx    = 3'(widx_ff - W_ISTAT);
   assign prm_slot     = PARAM_AW'(ima_slot(iaddr_ff));

   always_comb begin
      logic [DATA_W-1:0] chb;
      logic [DATA_W-1:0] eofb;
      conf_in      = conf_ff;
      buf0_in      = buf0_ff;
      buf1_in      = buf1_ff;
      dbsel_in     = dbsel_ff;
      cur_in       = cur_ff;
      iaddr_in     = iaddr_ff;
      chen_in      = chen_ff;
      ien_in       = ien_ff;
      istat_in     = istat_ff;
      gen_we       = 1'b0;
      gen_wdata    = wdata_ff;
      prm_we       = 1'b0;
      irq_upd      = 1'b0;
      rsp_rdata_in = '0;
      chb          = '0;
      eofb         = '0;
      if (cmd_i.exec) begin
         unique case (cmd_ff)
            CMD_READ: begin
               if (widx_ff == W_IDATA) begin
                  rsp_rdata_in = param_rdata_ff;
                  iaddr_in     = ima_step(iaddr_ff);
               end else if (in_range_ff) begin
                  unique case (widx_ff)
                     W_CONF:  rsp_rdata_in = conf_ff;
                     W_BUF0:  rsp_rdata_in = buf0_ff;
                     W_BUF1:  rsp_rdata_in = buf1_ff;
                     W_DBSEL: rsp_rdata_in = dbsel_ff;
                     W_CUR:   rsp_rdata_in = cur_ff;
                     W_IADDR: rsp_rdata_in = iaddr_ff;
                     W_CHEN:  rsp_rdata_in = chen_ff;
                     default: begin
                        if (is_ien) begin
                           rsp_rdata_in = ien_ff[ien_idx];
                        end else if (is_istat) begin
                           rsp_rdata_in = istat_ff[istat_idx];
                        end else begin
                           rsp_rdata_in = reg_word;
                        end
                     end
                  endcase
               end
            end
            CMD_WRITE: begin
               if (in_range_ff) begin
                  unique case (widx_ff)
                     W_CONF:  conf_in  = wdata_ff;
                     W_BUF0:  buf0_in  = buf0_ff | wdata_ff;
                     W_BUF1:  buf1_in  = buf1_ff | wdata_ff;
                     W_DBSEL: dbsel_in = wdata_ff;
                     W_CUR:   cur_in   = wdata_ff;
                     W_IADDR: iaddr_in = wdata_ff;
                     W_CHEN:  chen_in  = wdata_ff;
                     W_IDATA: begin
                        prm_we   = 1'b1;
                        iaddr_in = ima_step(iaddr_ff);
                     end
                     W_TASK: begin
                        gen_we    = 1'b1;
                        gen_wdata = reg_word & ~wdata_ff;
                     end
                     default: begin
                        if (is_ien) begin
                           ien_in[ien_idx] = wdata_ff;
                           irq_upd         = 1'b1;
                        end else if (is_istat) begin
                           istat_in[istat_idx] = istat_ff[istat_idx] & ~wdata_ff;
                           irq_upd             = 1'b1;
                        end else begin
                           gen_we = 1'b1;
                        end
                     end
                  endcase
               end
            end
            CMD_TICK: begin
               if (|(conf_ff & CONF_EN_MASK)) begin
                  for (int i = 0; i < 2; i++) begin
                     chb  = (i == 0) ? CH_A_MASK : CH_B_MASK;
                     eofb = (i == 0) ? EOF_A_MASK : EOF_B_MASK;
                     if (|(chen_in & chb)) begin
                        if (|(dbsel_in & chb)) begin
                           // flip only when the other buffer is ready
                           if (|(cur_in & chb)) begin
                              if (|(buf0_in & chb)) begin
                                 cur_in  = cur_in ^ chb;
                                 buf0_in = buf0_in & ~chb;
                              end
                           end else if (|(buf1_in & chb)) begin
                              cur_in  = cur_in ^ chb;
                              buf1_in = buf1_in & ~chb;
                           end
                        end else begin
                           buf0_in = buf0_in & ~chb;
                        end
                        istat_in[0] = istat_in[0] | chb;
                        istat_in[1] = istat_in[1] | chb;
                        istat_in[2] = istat_in[2] | eofb;
                     end
                  end
                  istat_in[2] = istat_in[2] | VSYNC_MASK;
                  irq_upd     = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      irq_any = 1'b0;
      irq_now = 1'b0;
      for (int i = 0; i < IRQ_WORDS; i++) begin
         irq_any = irq_any | (|(istat_in[i] & ien_in[i]));
         irq_now = irq_now | (|(istat_ff[i] & ien_ff[i]));
      end
      irq_in = irq_upd ? irq_any : irq_ff;
   end

   // parameter memory port: clearing pass or data port write
   assign prm_wen   = cmd_i.clear_we | prm_we;
   assign prm_waddr = cmd_i.clear_we ? cmd_i.clear_addr : prm_slot;
   assign prm_wdata = cmd_i.clear_we ? '0 : wdata_ff;

   always_ff @(posedge clock) begin
      if (prm_wen) begin
         param_mem[prm_waddr] <= prm_wdata;
      end
      if (cmd_i.load) begin
         param_rdata_ff <= param_mem[prm_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         reg_mem[widx_ff[REG_AW-1:0]] <= gen_wdata;
      end
      if (cmd_i.load && req_in_range) begin
         reg_rdata_ff <= reg_mem[req_word_index[REG_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         cmd_ff        <= req_command;
         widx_ff       <= req_word_index;
         wdata_ff      <= req_write_data;
         in_range_ff   <= req_in_range;
         reg_vld_rd_ff <= req_in_range ? reg_vld_ff[req_word_index[REG_AW-1:0]] : 1'b0;
      end
      rsp_rdata_ff <= rsp_rdata_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff   <= '0;
         conf_ff      <= '0;
         buf0_ff      <= '0;
         buf1_ff      <= '0;
         dbsel_ff     <= '0;
         cur_ff       <= '0;
         iaddr_ff     <= '0;
         chen_ff      <= '0;
         ien_ff       <= '{default: '0};
         istat_ff     <= '{default: '0};
         irq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (gen_we) begin
            reg_vld_ff[widx_ff[REG_AW-1:0]] <= 1'b1;
         end
         conf_ff      <= conf_in;
         buf0_ff      <= buf0_in;
         buf1_ff      <= buf1_in;
         dbsel_ff     <= dbsel_in;
         cur_ff       <= cur_in;
         iaddr_ff     <= iaddr_in;
         chen_ff      <= chen_in;
         ien_ff       <= ien_in;
         istat_ff     <= istat_in;
         irq_ff       <= irq_in;
         rsp_valid_ff <= cmd_i.exec;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_rdata_ff;
   assign rsp_irq_level = irq_ff;

   `DDRB_ASSERT(a_rsp_from_exec, rsp_valid_ff |-> $past(cmd_i.exec), "result without an executed item")
   `DDRB_ASSERT(a_rsp_single, rsp_valid_ff |=> !rsp_valid_ff, "two results in consecutive cycles")
   `DDRB_ASSERT(a_irq_tracks, irq_ff == irq_now, "interrupt line disagrees with status and enables")

endmodule

>>> design/display_dma_register_block_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// request  in         start high, busy low      req_command, req_word_index, req_write_data
// result   out        rsp_valid, one-cycle      rsp_read_data, rsp_irq_level
//
// The accept edge launches the registered reads of the register memory and the
// parameter memory; in the execute state the update is applied and the result is
// registered. rsp_valid strobes for one cycle at the start of the following cycle,
// and a new item may be accepted in that same cycle.
// After reset busy stays high while the parameter memory is swept to zero; the
// register words clear at once.
// The receiver cannot stall: a result is on the ports for its single cycle only.
module display_dma_register_block_top
   import ddrb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [WIDX_W-1:0] req_word_index,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_irq_level
);

   // load / execute / clear strobes from the sequencer
   ddrb_cmd_type ctrl_cmd;

   // sequencer: clearing pass, then accept-execute per item
   ddrb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd_o (ctrl_cmd)
   );

   // register words, parameter memory, interrupt line and result registers
   ddrb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd_i          (ctrl_cmd),
      .req_command    (req_command),
      .req_word_index (req_word_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq_level  (rsp_irq_level)
   );

endmodule

>>> tb/ddrb_checker.sv
`timescale 1ns / 1ps
module ddrb_checker
   import ddrb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [WIDX_W-1:0] req_word_index,
   input  logic [DATA_W-1:0] req_write_data,
   input  logic              rsp_valid,
   input  logic [DATA_W-1:0] rsp_read_data,
   input  logic              rsp_irq_level,
   output int                fail_count,
   output int                outstanding,
   output int                results_checked
);

   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_level;
   } response_type;

   logic [DATA_W-1:0] reg_words   [REG_WORDS];
   logic [DATA_W-1:0] param_words [PARAM_WORDS];
   logic              irq_line;
   response_type      expected_responses [$];
   int                errors  = 0;
   int                checked = 0;

   assign fail_count      = errors;
   assign results_checked = checked;

   // page << 11 | row << 3 | column
   function automatic logic [PARAM_AW-1:0] param_index(input logic [DATA_W-1:0] addr);
      return {addr[19:16], addr[10:3], addr[2:0]};
   endfunction

   // rows are five words, so columns 5..7 are skipped
   function automatic logic [DATA_W-1:0] next_param_addr(input logic [DATA_W-1:0] addr);
      logic [DATA_W-1:0] nxt;
      nxt = addr + 32'd1;
      if (nxt[2:0] == 3'd5) nxt = {nxt[DATA_W-1:3], 3'b000} + 32'd8;
      return nxt;
   endfunction

   function automatic logic irq_from_regs();
      logic any;
      any = 1'b0;
      for (int i = 0; i < IRQ_WORDS; i++)
         any |= |(reg_words[W_ISTAT + i] & reg_words[W_IEN + i]);
      return any;
   endfunction

   task automatic close_frame(input logic [DATA_W-1:0] ch_mask,
                              input logic [DATA_W-1:0] eof_mask);
      logic [WIDX_W-1:0] spare;
      if ((reg_words[W_CHEN] & ch_mask) == '0) return;
      if ((reg_words[W_DBSEL] & ch_mask) != '0) begin
         // flip only when the off-screen buffer is ready
         spare = ((reg_words[W_CUR] & ch_mask) != '0) ? W_BUF0 : W_BUF1;
         if ((reg_words[spare] & ch_mask) != '0) begin
            reg_words[W_CUR] ^= ch_mask;
            reg_words[spare] &= ~ch_mask;
         end
      end else begin
         reg_words[W_BUF0] &= ~ch_mask;
      end
      reg_words[W_ISTAT]     |= ch_mask;
      reg_words[W_ISTAT + 1] |= ch_mask;
      reg_words[W_ISTAT + 2] |= eof_mask;
   endtask

   task automatic predict_response(input  logic [CMD_W-1:0]  cmd,
                                   input  logic [WIDX_W-1:0] idx,
                                   input  logic [DATA_W-1:0] data,
                                   output response_type      resp);
      resp.read_data = '0;
      case (cmd)
         CMD_READ: begin
            if (idx == W_IDATA) begin
               resp.read_data     = param_words[param_index(reg_words[W_IADDR])];
               reg_words[W_IADDR] = next_param_addr(reg_words[W_IADDR]);
            end else if (idx < REG_WORDS) begin
               resp.read_data = reg_words[idx];
            end
         end
         CMD_WRITE: begin
            if (idx < REG_WORDS) begin
               if (idx == W_BUF0 || idx == W_BUF1) begin
                  reg_words[idx] |= data;
               end else if (idx == W_IDATA) begin
                  param_words[param_index(reg_words[W_IADDR])] = data;
                  reg_words[W_IADDR] = next_param_addr(reg_words[W_IADDR]);
               end else if (idx == W_TASK) begin
                  reg_words[idx] &= ~data;
               end else if (idx >= W_ISTAT && idx < W_ISTAT + IRQ_WORDS) begin
                  reg_words[idx] &= ~data;
                  irq_line = irq_from_regs();
               end else if (idx >= W_IEN && idx < W_IEN + IRQ_WORDS) begin
                  reg_words[idx] = data;
                  irq_line = irq_from_regs();
               end else begin
                  reg_words[idx] = data;
               end
            end
         end
         CMD_TICK: begin
            if ((reg_words[W_CONF] & CONF_EN_MASK) != '0) begin
               close_frame(CH_A_MASK, EOF_A_MASK);
               close_frame(CH_B_MASK, EOF_B_MASK);
               reg_words[W_ISTAT + 2] |= VSYNC_MASK;
               irq_line = irq_from_regs();
            end
         end
         default: ;
      endcase
      resp.irq_level = irq_line;
   endtask

   task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] wanted);
      errors++;
      if (errors <= MAX_PRINTED)
         $display("%0t: %s got %h, want %h", $time, field, got, wanted);
   endtask

   always @(posedge clock) begin : watch
      response_type fresh;
      response_type want;
      if (reset) begin
         for (int i = 0; i < REG_WORDS; i++) reg_words[i] = '0;
         for (int i = 0; i < PARAM_WORDS; i++) param_words[i] = '0;
         irq_line = 1'b0;
         expected_responses.delete();
      end else begin
         // predict first, so the queue is right whatever the latency
         if (start && !busy) begin
            predict_response(req_command, req_word_index, req_write_data, fresh);
            expected_responses.push_back(fresh);
         end
         if (rsp_valid) begin
            checked++;
            if (expected_responses.size() == 0) begin
               report_mismatch("result with no item outstanding", rsp_read_data, '0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_irq_level !== want.irq_level)
                  report_mismatch("irq_level", DATA_W'(rsp_irq_level),
                                  DATA_W'(want.irq_level));
            end
         end
      end
      outstanding <= expected_responses.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import ddrb_pkg::*;

   // command 3 is legal on the port but does nothing
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 1150;
   // parameter sweep after reset plus under 1200 items with their idle gaps and
   // drain pauses, then taken several times over
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT   = 1000;
   localparam int PAUSE_EVERY   = 300;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic              busy;
   logic [CMD_W-1:0]  req_command    = CMD_READ;
   logic [WIDX_W-1:0] req_word_index = '0;
   logic [DATA_W-1:0] req_write_data = '0;
   logic              rsp_valid;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_irq_level;

   int fail_count;
   int outstanding;
   int results_checked;
   int cycle_count    = 0;
   int cmd_count [4]  = '{default: 0};
   int items_sent     = 0;
   int drain_pauses   = 0;
   int param_bursts   = 0;
   int frame_sequences = 0;
   bit steady         = 1'b0;   // set during the stretch with no idle gaps

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   display_dma_register_block_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_word_index (req_word_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq_level  (rsp_irq_level)
   );

   ddrb_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_word_index  (req_word_index),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_level   (rsp_irq_level),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   // Watchdog: a hang (busy stuck, lost result) ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("display_dma_register_block_top: mismatch");
         $finish;
      end
   end

   // Present one item and hold it until the block takes it. An optional idle
   // gap goes first; start is only lowered in a step where it is not also
   // raised, so the next item can follow straight on from an accept edge.
   task automatic send_item(input logic [CMD_W-1:0]  cmd,
                            input logic [WIDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
      int gap;
      if (!steady && $urandom_range(0, 99) < 25) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_word_index <= idx;
      req_write_data <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      cmd_count[cmd]++;
   endtask

   initial begin
      int               pick;
      int               len;
      int               wait_cycles;
      int               next_pause;
      int               random_end;
      logic [DATA_W-1:0] base;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // everything reads zero after reset; the far end of the index space
      // reads zero and swallows writes
      send_item(CMD_READ,  W_CONF,  '0);
      send_item(CMD_READ,  10'h3FF, 32'hFFFF_FFFF);
      send_item(CMD_WRITE, 10'h3FF, 32'hFFFF_FFFF);
      // channel 14 single-buffered, channel 15 double-buffered, vsync irq enabled
      send_item(CMD_WRITE, W_CHEN,  CH_A_MASK | CH_B_MASK);
      send_item(CMD_WRITE, W_BUF0,  CH_A_MASK | CH_B_MASK);
      send_item(CMD_WRITE, W_BUF1,  CH_B_MASK);
      send_item(CMD_WRITE, W_DBSEL, CH_B_MASK);
      send_item(CMD_WRITE, W_IEN + 10'd2, VSYNC_MASK);
      // tick with the display still off: no effect
      send_item(CMD_TICK,  '0, '0);
      send_item(CMD_WRITE, W_CONF,  CONF_EN_MASK);
      // first two ticks flip channel 15, the third finds no ready buffer
      repeat (3) send_item(CMD_TICK, '0, '0);
      send_item(CMD_READ,  W_CUR,   '0);
      send_item(CMD_READ,  W_ISTAT + 10'd2, '0);
      // write-one-to-clear drops the interrupt line
      send_item(CMD_WRITE, W_ISTAT + 10'd2, 32'hFFFF_FFFF);
      send_item(CMD_WRITE, W_TASK,  32'hFFFF_FFFF);
      // data port at the top of the address space, then wrap to zero
      send_item(CMD_WRITE, W_IADDR, 32'hFFFF_FFFC);
      send_item(CMD_WRITE, W_IDATA, 32'hFFFF_FFFF);
      send_item(CMD_WRITE, W_IDATA, 32'h0000_0000);
      send_item(CMD_WRITE, W_IADDR, 32'hFFFF_FFFC);
      repeat (2) send_item(CMD_READ, W_IDATA, '0);
      // last word of the file, and the unused command
      send_item(CMD_WRITE, 10'd63,  32'hA5A5_5A5A);
      send_item(CMD_READ,  10'd63,  '0);
      send_item(CMD_UNUSED, 10'h3FF, 32'hFFFF_FFFF);

      // --- random part ---
      // First pause comes straight after the directed items.
      next_pause = items_sent;
      random_end = items_sent + RANDOM_ITEMS;
      while (items_sent < random_end) begin
         steady = (items_sent >= 400 && items_sent < 650);
         if (items_sent >= next_pause) begin
            // hold off until every outstanding result is back
            start <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
            drain_pauses++;
            next_pause += PAUSE_EVERY;
         end
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_item(CMD_TICK, WIDX_W'($urandom), $urandom);
         end else if (pick < 22) begin
            // parameter burst: write a run through the data port, then read it back;
            // mostly a small address window so slots get reused
            base = ($urandom_range(0, 3) != 0) ? ($urandom & 32'h000F_003F) : $urandom;
            len  = $urandom_range(1, 8);
            send_item(CMD_WRITE, W_IADDR, base);
            repeat (len) send_item(CMD_WRITE, W_IDATA, $urandom);
            send_item(CMD_WRITE, W_IADDR, base);
            repeat (len) send_item(CMD_READ, W_IDATA, $urandom);
            param_bursts++;
         end else if (pick < 30) begin
            // frame: mark buffers ready, tick, look at the result, clear status
            send_item(CMD_WRITE, W_BUF0,
                      $urandom_range(0, 1) ? $urandom : (CH_A_MASK | CH_B_MASK));
            send_item(CMD_WRITE, W_BUF1,
                      $urandom_range(0, 1) ? $urandom : (CH_A_MASK | CH_B_MASK));
            send_item(CMD_TICK, WIDX_W'($urandom), $urandom);
            send_item(CMD_READ, W_CUR, $urandom);
            send_item(CMD_READ, W_ISTAT + WIDX_W'($urandom_range(0, IRQ_WORDS - 1)),
                      $urandom);
            send_item(CMD_WRITE, W_ISTAT + WIDX_W'($urandom_range(0, IRQ_WORDS - 1)),
                      $urandom);
            frame_sequences++;
         end else if (pick < 40) begin
            // control words, biased towards display and channels on
            case ($urandom_range(0, 3))
               0: send_item(CMD_WRITE, W_CONF,
                            $urandom_range(0, 4) != 0 ? ($urandom | CONF_EN_MASK) : $urandom);
               1: send_item(CMD_WRITE, W_DBSEL, $urandom);
               2: send_item(CMD_WRITE, W_CHEN,
                            $urandom_range(0, 3) != 0 ?
                            ($urandom | CH_A_MASK | CH_B_MASK) : $urandom);
               default: send_item(CMD_WRITE, W_TASK, $urandom);
            endcase
         end else if (pick < 52) begin
            // interrupt enables and status
            send_item(CMD_WRITE, W_IEN + WIDX_W'($urandom_range(0, 2 * IRQ_WORDS - 1)),
                      $urandom);
         end else if (pick < 80) begin
            send_item(CMD_READ, WIDX_W'($urandom_range(0, REG_WORDS - 1)), $urandom);
         end else if (pick < 88) begin
            send_item(CMD_WRITE, WIDX_W'($urandom_range(0, REG_WORDS - 1)), $urandom);
         end else if (pick < 96) begin
            // beyond the file
            send_item($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                      WIDX_W'($urandom_range(REG_WORDS, 1023)), $urandom);
         end else begin
            send_item(CMD_UNUSED, WIDX_W'($urandom), $urandom);
         end
      end

      // --- wind-down ---
      start <= 1'b0;
      @(posedge clock);
      for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && outstanding != 0; wait_cycles++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d reads, %0d writes, %0d frame ticks, %0d unused;",
               items_sent, cmd_count[CMD_READ], cmd_count[CMD_WRITE], cmd_count[CMD_TICK],
               cmd_count[CMD_UNUSED]);
      $display("%0d parameter bursts, %0d frame sequences, %0d drain pauses, %0d checked, %0d lost.",
               param_bursts, frame_sequences, drain_pauses, results_checked, outstanding);
      if (fail_count == 0 && outstanding == 0) begin
         $display("display_dma_register_block_top: match");
      end else begin
         $display("display_dma_register_block_top: mismatch");
      end
      $finish;
   end

endmodule
